FILE: sv/hid_report_descriptor_parser_unit_assert.svh
// assertion macros for the hid report descriptor parser unit
// no dependencies; simulation builds get the checks, synthesis gets empty bodies
`ifndef HID_REPORT_DESCRIPTOR_PARSER_UNIT_ASSERT_SVH
`define HID_REPORT_DESCRIPTOR_PARSER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define HRDP_ASSERT(label, clk, rstn, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (expr)) else $error(msg);
`define HRDP_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
`define HRDP_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define HRDP_ASSERT(label, clk, rstn, expr, msg)
`define HRDP_ASSERT_SAME(label, clk, rstn, ante, cons, msg)
`define HRDP_ASSERT_NEXT(label, clk, rstn, ante, cons, msg)
`endif
`endif

FILE: sv/hrdp_pkg.sv
// types and codes shared by the hid report descriptor parser
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package hrdp_pkg;

    localparam logic [7:0] LONG_PREFIX = 8'hFE;
    localparam logic [7:0] END_PREFIX  = 8'h00;

    localparam logic [1:0] TYPE_MAIN   = 2'd0;
    localparam logic [1:0] TYPE_GLOBAL = 2'd1;
    localparam logic [1:0] TYPE_LOCAL  = 2'd2;

    localparam logic [3:0] TAG_INPUT      = 4'd8;
    localparam logic [3:0] TAG_OUTPUT     = 4'd9;
    localparam logic [3:0] TAG_COLLECTION = 4'd10;
    localparam logic [3:0] TAG_FEATURE    = 4'd11;
    localparam logic [3:0] TAG_END_COLL   = 4'd12;

    localparam logic [3:0] TAG_USAGE_PAGE   = 4'd0;
    localparam logic [3:0] TAG_REPORT_SIZE  = 4'd7;
    localparam logic [3:0] TAG_REPORT_ID    = 4'd8;
    localparam logic [3:0] TAG_REPORT_COUNT = 4'd9;

    localparam logic [3:0] TAG_USAGE     = 4'd0;
    localparam logic [3:0] TAG_USAGE_MIN = 4'd1;
    localparam logic [3:0] TAG_USAGE_MAX = 4'd2;

    localparam logic [1:0] SIZE_FOUR = 2'd3;

    localparam logic [1:0] RPT_INPUT   = 2'd0;
    localparam logic [1:0] RPT_OUTPUT  = 2'd1;
    localparam logic [1:0] RPT_FEATURE = 2'd2;

    localparam logic [1:0] USAGE_NONE  = 2'd0;
    localparam logic [1:0] USAGE_FIRST = 2'd1;
    localparam logic [1:0] USAGE_MIN   = 2'd2;

    typedef struct packed {
        logic [15:0] usage_max;
        logic [15:0] usage_min;
        logic        usage_seen;
        logic [15:0] usage_first;
        logic [7:0]  id;
        logic [15:0] count;
        logic [15:0] size;
        logic [15:0] page;
    } stack_entry_t;

endpackage

`default_nettype wire

FILE: sv/hid_report_descriptor_parser_unit.sv
// hid report descriptor parser: one descriptor byte in, at most one report record out
// depends on hrdp_pkg and hid_report_descriptor_parser_unit_assert.svh
//
//  channel | ports           | tdata (low bit up)                         | tuser / tlast
//  --------+-----------------+--------------------------------------------+-------------------
//  in      | s_tvalid/tready | data_byte                                  | first_byte / last_byte
//  out     | m_tvalid/tready | report_id, report_bits, page, usage_code   | report_type, usage_kind
//
// one byte per cycle unless the output stalls; a record passes the input and result registers
// collection stack is a memory with a registered top-of-stack read, refreshed every step
// synchronous active-low reset clears control state; the stack is not cleared
// a stalled output holds the input register, which then stalls the input side
`timescale 1ns / 1ps
`default_nettype none
`include "hid_report_descriptor_parser_unit_assert.svh"

module hid_report_descriptor_parser_unit #(
    parameter int STACK_DEPTH = 8
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // data_byte
    input  wire logic        s_tuser,   // first_byte
    input  wire logic        s_tlast,   // last_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [71:0]      m_tdata,   // report_id, report_bits, usage_page, usage_code
    output logic [3:0]       m_tuser    // report_type, usage_kind
);

    localparam int NEST_W = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam logic [NEST_W-1:0] NEST_MAX = NEST_W'(STACK_DEPTH);
    localparam logic [NEST_W-1:0] NEST_ONE = NEST_W'(1);

    typedef enum logic [1:0] {
        LP_NONE,
        LP_SIZE,
        LP_TAG,
        LP_SKIP
    } long_phase_t;

    // input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_first_reg;
    logic       in_last_reg;

    // parser state
    logic [7:0]        bytes_left_reg, bytes_left_next;
    logic [7:0]        item_header_reg, item_header_next;
    logic [31:0]       item_value_reg, item_value_next;
    logic [1:0]        byte_index_reg, byte_index_next;
    long_phase_t       long_phase_reg, long_phase_next;
    logic              halted_reg, halted_next;
    logic [15:0]       page_reg, page_next;
    logic [15:0]       size_reg, size_next;
    logic [15:0]       count_reg, count_next;
    logic [7:0]        id_reg, id_next;
    logic [15:0]       usage_first_reg, usage_first_next;
    logic              usage_seen_reg, usage_seen_next;
    logic [15:0]       usage_min_reg, usage_min_next;
    logic [15:0]       usage_max_reg, usage_max_next;
    logic [NEST_W-1:0] nest_reg, nest_next;

    hrdp_pkg::stack_entry_t stack_mem [STACK_DEPTH];
    hrdp_pkg::stack_entry_t top_reg;
    hrdp_pkg::stack_entry_t push_val;
    logic                   push_en;
    logic [IDX_W-1:0]       rd_addr;

    // result register
    logic        m_valid_reg;
    logic [7:0]  out_id_reg;
    logic [1:0]  out_type_reg, out_type_next;
    logic [31:0] out_bits_reg;
    logic [15:0] out_page_reg;
    logic [15:0] out_code_reg, out_code_next;
    logic [1:0]  out_kind_reg, out_kind_next;

    logic        advance;
    logic        emit;

    assign advance  = in_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_comb begin
        logic        run;
        logic [1:0]  ty;
        logic [3:0]  tg;
        logic [15:0] v16;
        logic [1:0]  sz;

        bytes_left_next  = bytes_left_reg;
        item_header_next = item_header_reg;
        item_value_next  = item_value_reg;
        byte_index_next  = byte_index_reg;
        long_phase_next  = long_phase_reg;
        halted_next      = halted_reg;
        page_next        = page_reg;
        size_next        = size_reg;
        count_next       = count_reg;
        id_next          = id_reg;
        usage_first_next = usage_first_reg;
        usage_seen_next  = usage_seen_reg;
        usage_min_next   = usage_min_reg;
        usage_max_next   = usage_max_reg;
        nest_next        = nest_reg;
        push_en          = 1'b0;
        emit             = 1'b0;
        out_type_next    = hrdp_pkg::RPT_INPUT;
        out_code_next    = '0;
        out_kind_next    = hrdp_pkg::USAGE_NONE;
        run              = 1'b0;
        sz               = in_byte_reg[1:0];

        if (in_first_reg) begin
            bytes_left_next  = '0;
            item_header_next = '0;
            item_value_next  = '0;
            byte_index_next  = '0;
            long_phase_next  = LP_NONE;
            halted_next      = 1'b0;
            page_next        = '0;
            size_next        = '0;
            count_next       = '0;
            id_next          = '0;
            usage_first_next = '0;
            usage_seen_next  = 1'b0;
            usage_min_next   = '0;
            usage_max_next   = '0;
            nest_next        = '0;
        end

        push_val.page        = page_next;
        push_val.size        = size_next;
        push_val.count       = count_next;
        push_val.id          = id_next;
        push_val.usage_first = usage_first_next;
        push_val.usage_seen  = usage_seen_next;
        push_val.usage_min   = usage_min_next;
        push_val.usage_max   = usage_max_next;

        if (!halted_next) begin
            case (long_phase_next)
                LP_SIZE: begin
                    bytes_left_next = in_byte_reg;
                    long_phase_next = LP_TAG;
                end
                LP_TAG: begin
                    long_phase_next = (bytes_left_next == 8'd0) ? LP_NONE : LP_SKIP;
                end
                LP_SKIP: begin
                    bytes_left_next = bytes_left_next - 8'd1;
                    if (bytes_left_next == 8'd0) begin
                        long_phase_next = LP_NONE;
                    end
                end
                default: begin
                    if (bytes_left_next == 8'd0) begin
                        if (in_byte_reg == hrdp_pkg::END_PREFIX) begin
                            halted_next = 1'b1;
                        end else if (in_byte_reg == hrdp_pkg::LONG_PREFIX) begin
                            long_phase_next = LP_SIZE;
                        end else begin
                            item_header_next = in_byte_reg;
                            item_value_next  = '0;
                            byte_index_next  = '0;
                            bytes_left_next  = (sz == hrdp_pkg::SIZE_FOUR) ? 8'd4 : {6'd0, sz};
                            if (bytes_left_next == 8'd0 || in_last_reg) begin
                                bytes_left_next = '0;
                                run = 1'b1;
                            end
                        end
                    end else begin
                        case (byte_index_next)
                            2'd0:    item_value_next[7:0]   = item_value_next[7:0] | in_byte_reg;
                            2'd1:    item_value_next[15:8]  = item_value_next[15:8] | in_byte_reg;
                            2'd2:    item_value_next[23:16] = item_value_next[23:16] | in_byte_reg;
                            default: item_value_next[31:24] = item_value_next[31:24] | in_byte_reg;
                        endcase
                        byte_index_next = byte_index_next + 2'd1;
                        bytes_left_next = bytes_left_next - 8'd1;
                        if (bytes_left_next == 8'd0 || in_last_reg) begin
                            bytes_left_next = '0;
                            run = 1'b1;
                        end
                    end
                end
            endcase

            if (in_last_reg) begin
                halted_next     = 1'b1;
                bytes_left_next = '0;
                long_phase_next = LP_NONE;
            end
        end

        ty  = item_header_next[3:2];
        tg  = item_header_next[7:4];
        v16 = item_value_next[15:0];

        if (run) begin
            case (ty)
                hrdp_pkg::TYPE_MAIN: begin
                    if (tg inside {hrdp_pkg::TAG_INPUT, hrdp_pkg::TAG_OUTPUT,
                                   hrdp_pkg::TAG_FEATURE}) begin
                        emit = 1'b1;
                        if (usage_seen_next) begin
                            out_code_next = usage_first_next;
                            out_kind_next = hrdp_pkg::USAGE_FIRST;
                        end else if (usage_min_next != 16'd0 || usage_max_next != 16'd0) begin
                            out_code_next = usage_min_next;
                            out_kind_next = hrdp_pkg::USAGE_MIN;
                        end
                        case (tg)
                            hrdp_pkg::TAG_INPUT:  out_type_next = hrdp_pkg::RPT_INPUT;
                            hrdp_pkg::TAG_OUTPUT: out_type_next = hrdp_pkg::RPT_OUTPUT;
                            default:              out_type_next = hrdp_pkg::RPT_FEATURE;
                        endcase
                        usage_seen_next  = 1'b0;
                        usage_first_next = '0;
                        usage_min_next   = '0;
                        usage_max_next   = '0;
                    end else if (tg == hrdp_pkg::TAG_COLLECTION) begin
                        if (nest_next < NEST_MAX) begin
                            push_en   = 1'b1;
                            nest_next = nest_next + NEST_ONE;
                        end
                    end else if (tg == hrdp_pkg::TAG_END_COLL) begin
                        if (nest_next != '0) begin
                            nest_next        = nest_next - NEST_ONE;
                            page_next        = top_reg.page;
                            size_next        = top_reg.size;
                            count_next       = top_reg.count;
                            id_next          = top_reg.id;
                            usage_first_next = top_reg.usage_first;
                            usage_seen_next  = top_reg.usage_seen;
                            usage_min_next   = top_reg.usage_min;
                            usage_max_next   = top_reg.usage_max;
                        end
                    end
                end
                hrdp_pkg::TYPE_GLOBAL: begin
                    case (tg)
                        hrdp_pkg::TAG_USAGE_PAGE:   page_next  = v16;
                        hrdp_pkg::TAG_REPORT_SIZE:  size_next  = v16;
                        hrdp_pkg::TAG_REPORT_ID:    id_next    = item_value_next[7:0];
                        hrdp_pkg::TAG_REPORT_COUNT: count_next = v16;
                        default: ;
                    endcase
                end
                hrdp_pkg::TYPE_LOCAL: begin
                    case (tg)
                        hrdp_pkg::TAG_USAGE: begin
                            if (!usage_seen_next) begin
                                usage_first_next = v16;
                                usage_seen_next  = 1'b1;
                            end
                        end
                        hrdp_pkg::TAG_USAGE_MIN: usage_min_next = v16;
                        hrdp_pkg::TAG_USAGE_MAX: usage_max_next = v16;
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end

        // top of stack after this step, read from entry nest_next - 1
        rd_addr = (nest_next == '0) ? '0 : IDX_W'(nest_next - NEST_ONE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            m_valid_reg     <= 1'b0;
            bytes_left_reg  <= '0;
            item_header_reg <= '0;
            item_value_reg  <= '0;
            byte_index_reg  <= '0;
            long_phase_reg  <= LP_NONE;
            halted_reg      <= 1'b0;
            page_reg        <= '0;
            size_reg        <= '0;
            count_reg       <= '0;
            id_reg          <= '0;
            usage_first_reg <= '0;
            usage_seen_reg  <= 1'b0;
            usage_min_reg   <= '0;
            usage_max_reg   <= '0;
            nest_reg        <= '0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance && emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (advance) begin
                bytes_left_reg  <= bytes_left_next;
                item_header_reg <= item_header_next;
                item_value_reg  <= item_value_next;
                byte_index_reg  <= byte_index_next;
                long_phase_reg  <= long_phase_next;
                halted_reg      <= halted_next;
                page_reg        <= page_next;
                size_reg        <= size_next;
                count_reg       <= count_next;
                id_reg          <= id_next;
                usage_first_reg <= usage_first_next;
                usage_seen_reg  <= usage_seen_next;
                usage_min_reg   <= usage_min_next;
                usage_max_reg   <= usage_max_next;
                nest_reg        <= nest_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg  <= s_tdata;
            in_first_reg <= s_tuser;
            in_last_reg  <= s_tlast;
        end
        if (advance && emit) begin
            out_id_reg   <= id_reg & {8{!in_first_reg}};
            out_type_reg <= out_type_next;
            out_bits_reg <= in_first_reg ? 32'd0 : 32'(size_reg) * 32'(count_reg);
            out_page_reg <= in_first_reg ? 16'd0 : page_reg;
            out_code_reg <= out_code_next;
            out_kind_reg <= out_kind_next;
        end
    end

    // collection stack, top entry read through a register with write bypass
    always_ff @(posedge aclk) begin
        if (advance) begin
            if (push_en) begin
                stack_mem[nest_reg[IDX_W-1:0] & {IDX_W{!in_first_reg}}] <= push_val;
                top_reg <= push_val;
            end else begin
                top_reg <= stack_mem[rd_addr];
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {out_code_reg, out_page_reg, out_bits_reg, out_id_reg};
    assign m_tuser  = {out_kind_reg, out_type_reg};

    `HRDP_ASSERT(a_nest_bound, aclk, aresetn, nest_reg <= NEST_MAX, "nest level beyond stack depth")
    `HRDP_ASSERT_SAME(a_halt_quiet, aclk, aresetn, advance && halted_reg && !in_first_reg, !emit && !push_en, "halted parser produced work")
    `HRDP_ASSERT_NEXT(a_in_hold, aclk, aresetn, in_valid_reg && !advance, in_valid_reg, "stalled request dropped from input register")

endmodule

`default_nettype wire

FILE: test/tb_hid_report_descriptor_parser_unit.sv
// self-checking bench for hid_report_descriptor_parser_unit: hand-built and random descriptors
// go in a byte at a time, an in-bench parser predicts every report record and checks the output
// depends on hrdp_pkg and hid_report_descriptor_parser_unit
`timescale 1ns / 1ps

module tb_hid_report_descriptor_parser_unit;

    localparam int STACK_DEPTH   = 8;
    localparam int TARGET_BYTES  = 650;
    localparam int HOLD_AT       = 200;
    localparam int HOLD_CYCLES   = 400;
    localparam int DRAIN_AT      = 420;
    localparam int QUIET_TAIL    = 80;
    localparam int SETTLE_CYCLES = 16;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int MAX_PRINTED   = 100;

    localparam logic [1:0] TYPE_RESERVED = 2'd3;
    localparam logic [1:0] SIZE_NONE     = 2'd0;
    localparam logic [1:0] SIZE_ONE      = 2'd1;
    localparam logic [1:0] SIZE_TWO      = 2'd2;

    typedef enum logic [1:0] {SKIP_NONE, SKIP_LEN, SKIP_TAG, SKIP_DATA} skip_phase_t;

    typedef struct packed {
        logic [7:0]  id;
        logic [1:0]  rtype;
        logic [31:0] bits;
        logic [15:0] page;
        logic [15:0] code;
        logic [1:0]  kind;
    } report_rec_t;

    typedef struct packed {
        logic [7:0] data;
        logic       first;
        logic       last;
        logic       drain_before;
    } desc_byte_t;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;
    logic        s_tuser  = 1'b0;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;
    logic [3:0]  m_tuser;

    hid_report_descriptor_parser_unit #(
        .STACK_DEPTH(STACK_DEPTH)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    // stimulus
    desc_byte_t  byte_stream[$];
    logic [7:0]  desc_q[$];
    int          stream_bytes = 0;
    int          total_bytes  = 0;
    bit          drain_placed = 0;

    // parser model
    logic [7:0]   pr_left;
    logic [7:0]   pr_hdr;
    logic [31:0]  pr_val;
    logic [1:0]   pr_idx;
    skip_phase_t  pr_long;
    bit           pr_halted;
    logic [15:0]  pr_page, pr_size, pr_count, pr_ufirst, pr_umin, pr_umax;
    logic [7:0]   pr_id;
    bit           pr_useen;
    int           pr_nest;
    hrdp_pkg::stack_entry_t pr_stack[STACK_DEPTH];
    report_rec_t  predicted_reports[$];

    int n_reports  = 0;
    int deepest    = 0;
    int full_drops = 0;
    int long_items = 0;
    int halts      = 0;
    int mismatches = 0;

    // handshake bookkeeping
    desc_byte_t on_bus;
    int         tx_gap       = 0;
    int         rx_gap       = 0;
    int         accepted_cnt = 0;
    int         hold_left    = 0;
    bit         hold_done    = 0;
    int         cycles       = 0;

    task automatic log_mismatch(string what, logic [31:0] got, logic [31:0] want);
        mismatches++;
        if (mismatches <= MAX_PRINTED)
            $display("MISMATCH at %0t: %s got 0x%0h, predicted 0x%0h", $time, what, got, want);
    endtask

    function automatic void queue_byte(logic [7:0] b);
        desc_q.insert(desc_q.size(), b);
    endfunction

    function automatic void clear_parser();
        pr_left   = '0;
        pr_hdr    = '0;
        pr_val    = '0;
        pr_idx    = '0;
        pr_long   = SKIP_NONE;
        pr_halted = 0;
        pr_page   = '0;
        pr_size   = '0;
        pr_count  = '0;
        pr_id     = '0;
        pr_ufirst = '0;
        pr_useen  = 0;
        pr_umin   = '0;
        pr_umax   = '0;
        pr_nest   = 0;
    endfunction

    function automatic void close_item();
        logic [1:0]   ity;
        logic [3:0]   itag;
        logic [15:0]  v16;
        report_rec_t  rec;
        hrdp_pkg::stack_entry_t top;
        ity  = pr_hdr[3:2];
        itag = pr_hdr[7:4];
        v16  = pr_val[15:0];
        if (ity == hrdp_pkg::TYPE_MAIN) begin
            if (itag == hrdp_pkg::TAG_INPUT || itag == hrdp_pkg::TAG_OUTPUT ||
                itag == hrdp_pkg::TAG_FEATURE) begin
                rec.id    = pr_id;
                rec.rtype = (itag == hrdp_pkg::TAG_INPUT) ? hrdp_pkg::RPT_INPUT :
                            (itag == hrdp_pkg::TAG_OUTPUT) ? hrdp_pkg::RPT_OUTPUT :
                            hrdp_pkg::RPT_FEATURE;
                rec.bits  = 32'(pr_size) * 32'(pr_count);
                rec.page  = pr_page;
                if (pr_useen) begin
                    rec.code = pr_ufirst;
                    rec.kind = hrdp_pkg::USAGE_FIRST;
                end else if (pr_umin != 0 || pr_umax != 0) begin
                    rec.code = pr_umin;
                    rec.kind = hrdp_pkg::USAGE_MIN;
                end else begin
                    rec.code = '0;
                    rec.kind = hrdp_pkg::USAGE_NONE;
                end
                predicted_reports.insert(predicted_reports.size(), rec);
                n_reports++;
                pr_useen  = 0;
                pr_ufirst = '0;
                pr_umin   = '0;
                pr_umax   = '0;
            end else if (itag == hrdp_pkg::TAG_COLLECTION) begin
                if (pr_nest < STACK_DEPTH) begin
                    top.page        = pr_page;
                    top.size        = pr_size;
                    top.count       = pr_count;
                    top.id          = pr_id;
                    top.usage_first = pr_ufirst;
                    top.usage_seen  = pr_useen;
                    top.usage_min   = pr_umin;
                    top.usage_max   = pr_umax;
                    pr_stack[pr_nest] = top;
                    pr_nest++;
                    if (pr_nest > deepest) deepest = pr_nest;
                end else begin
                    full_drops++;
                end
            end else if (itag == hrdp_pkg::TAG_END_COLL) begin
                if (pr_nest > 0) begin
                    pr_nest--;
                    top       = pr_stack[pr_nest];
                    pr_page   = top.page;
                    pr_size   = top.size;
                    pr_count  = top.count;
                    pr_id     = top.id;
                    pr_ufirst = top.usage_first;
                    pr_useen  = top.usage_seen;
                    pr_umin   = top.usage_min;
                    pr_umax   = top.usage_max;
                end
            end
        end else if (ity == hrdp_pkg::TYPE_GLOBAL) begin
            case (itag)
                hrdp_pkg::TAG_USAGE_PAGE:   pr_page  = v16;
                hrdp_pkg::TAG_REPORT_SIZE:  pr_size  = v16;
                hrdp_pkg::TAG_REPORT_ID:    pr_id    = pr_val[7:0];
                hrdp_pkg::TAG_REPORT_COUNT: pr_count = v16;
                default: ;
            endcase
        end else if (ity == hrdp_pkg::TYPE_LOCAL) begin
            case (itag)
                hrdp_pkg::TAG_USAGE: begin
                    if (!pr_useen) begin
                        pr_ufirst = v16;
                        pr_useen  = 1;
                    end
                end
                hrdp_pkg::TAG_USAGE_MIN: pr_umin = v16;
                hrdp_pkg::TAG_USAGE_MAX: pr_umax = v16;
                default: ;
            endcase
        end
    endfunction

    function automatic void parse_byte(desc_byte_t b);
        if (b.first) clear_parser();
        if (pr_halted) return;
        if (pr_long == SKIP_LEN) begin
            pr_left = b.data;
            pr_long = SKIP_TAG;
        end else if (pr_long == SKIP_TAG) begin
            pr_long = (pr_left == 0) ? SKIP_NONE : SKIP_DATA;
        end else if (pr_long == SKIP_DATA) begin
            pr_left = pr_left - 8'd1;
            if (pr_left == 0) pr_long = SKIP_NONE;
        end else if (pr_left == 0) begin
            if (b.data == hrdp_pkg::END_PREFIX) begin
                pr_halted = 1;
                halts++;
                return;
            end
            if (b.data == hrdp_pkg::LONG_PREFIX) begin
                pr_long = SKIP_LEN;
                pr_left = '0;
                long_items++;
            end else begin
                pr_hdr  = b.data;
                pr_val  = '0;
                pr_idx  = '0;
                pr_left = (b.data[1:0] == hrdp_pkg::SIZE_FOUR) ? 8'd4 : {6'd0, b.data[1:0]};
                if (pr_left == 0 || b.last) begin
                    pr_left = '0;
                    close_item();
                end
            end
        end else begin
            pr_val  = pr_val | (32'(b.data) << {pr_idx, 3'b000});
            pr_idx  = pr_idx + 2'd1;
            pr_left = pr_left - 8'd1;
            if (pr_left == 0 || b.last) begin
                pr_left = '0;
                close_item();
            end
        end
        if (b.last) begin
            pr_halted = 1;
            pr_left   = '0;
            pr_long   = SKIP_NONE;
        end
    endfunction

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 3))
            0: return '0;
            1: return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic void emit_short(logic [1:0] ity, logic [3:0] itag, logic [1:0] isz,
                                       logic [31:0] val);
        int n;
        queue_byte({itag, ity, isz});
        n = (isz == hrdp_pkg::SIZE_FOUR) ? 4 : int'(isz);
        for (int k = 0; k < n; k++) queue_byte(val[8*k +: 8]);
    endfunction

    function automatic void flush_descriptor(bit with_last);
        desc_byte_t b;
        bit         mark;
        mark = !drain_placed && stream_bytes >= DRAIN_AT;
        for (int k = 0; k < desc_q.size(); k++) begin
            b.data         = desc_q[k];
            b.first        = (k == 0);
            b.last         = with_last && (k == desc_q.size() - 1);
            b.drain_before = mark && (k == 0);
            byte_stream.insert(byte_stream.size(), b);
        end
        if (mark) drain_placed = 1;
        stream_bytes += desc_q.size();
        desc_q.delete();
    endfunction

    task automatic gen_descriptor();
        int         n_items, pick, n;
        bit         with_last;
        logic [3:0] tg;
        desc_byte_t junk;
        with_last = ($urandom_range(0, 9) != 0);
        if ($urandom_range(0, 9) == 0) begin
            // raw noise
            n = $urandom_range(1, 16);
            for (int k = 0; k < n; k++) queue_byte(8'($urandom));
        end else begin
            n_items = $urandom_range(2, 24);
            for (int k = 0; k < n_items; k++) begin
                pick = $urandom_range(0, 99);
                if (pick < 20) begin
                    case ($urandom_range(0, 4))
                        0: tg = hrdp_pkg::TAG_USAGE_PAGE;
                        1: tg = hrdp_pkg::TAG_REPORT_SIZE;
                        2: tg = hrdp_pkg::TAG_REPORT_ID;
                        3: tg = hrdp_pkg::TAG_REPORT_COUNT;
                        default: tg = 4'($urandom_range(1, 6));
                    endcase
                    emit_short(hrdp_pkg::TYPE_GLOBAL, tg, 2'($urandom_range(0, 3)),
                               rand_value());
                end else if (pick < 40) begin
                    case ($urandom_range(0, 3))
                        0: tg = hrdp_pkg::TAG_USAGE;
                        1: tg = hrdp_pkg::TAG_USAGE_MIN;
                        2: tg = hrdp_pkg::TAG_USAGE_MAX;
                        default: tg = 4'($urandom_range(3, 15));
                    endcase
                    emit_short(hrdp_pkg::TYPE_LOCAL, tg, 2'($urandom_range(0, 3)),
                               rand_value());
                end else if (pick < 58) begin
                    case ($urandom_range(0, 2))
                        0: tg = hrdp_pkg::TAG_INPUT;
                        1: tg = hrdp_pkg::TAG_OUTPUT;
                        default: tg = hrdp_pkg::TAG_FEATURE;
                    endcase
                    emit_short(hrdp_pkg::TYPE_MAIN, tg, 2'($urandom_range(0, 2)), rand_value());
                end else if (pick < 68) begin
                    emit_short(hrdp_pkg::TYPE_MAIN, hrdp_pkg::TAG_COLLECTION,
                               2'($urandom_range(0, 1)), rand_value());
                end else if (pick < 78) begin
                    emit_short(hrdp_pkg::TYPE_MAIN, hrdp_pkg::TAG_END_COLL, SIZE_NONE, '0);
                end else if (pick < 84) begin
                    n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 4);
                    queue_byte(hrdp_pkg::LONG_PREFIX);
                    queue_byte(8'(n));
                    queue_byte(8'($urandom));
                    for (int j = 0; j < n; j++) queue_byte(8'($urandom));
                end else if (pick < 90) begin
                    // reserved type or unused main tags
                    if ($urandom_range(0, 1) == 0)
                        emit_short(TYPE_RESERVED, 4'($urandom), 2'($urandom_range(0, 3)),
                                   rand_value());
                    else
                        emit_short(hrdp_pkg::TYPE_MAIN, 4'($urandom_range(0, 7)),
                                   2'($urandom_range(0, 3)), rand_value());
                end else if (pick < 93) begin
                    queue_byte(hrdp_pkg::END_PREFIX);
                    n = $urandom_range(1, 3);
                    for (int j = 0; j < n; j++) queue_byte(8'($urandom));
                    break;
                end else begin
                    // nest up to or past the stack depth, report, then unwind one too far
                    n = $urandom_range(7, 11);
                    for (int j = 0; j < n; j++)
                        emit_short(hrdp_pkg::TYPE_MAIN, hrdp_pkg::TAG_COLLECTION, SIZE_ONE,
                                   rand_value());
                    emit_short(hrdp_pkg::TYPE_LOCAL, hrdp_pkg::TAG_USAGE, SIZE_TWO, rand_value());
                    emit_short(hrdp_pkg::TYPE_MAIN, hrdp_pkg::TAG_INPUT, SIZE_ONE, rand_value());
                    for (int j = 0; j <= n; j++)
                        emit_short(hrdp_pkg::TYPE_MAIN, hrdp_pkg::TAG_END_COLL, SIZE_NONE, '0);
                end
            end
        end
        if (with_last && desc_q.size() > 3 && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 3);
            for (int k = 0; k < n; k++) void'(desc_q.pop_back());
        end
        flush_descriptor(with_last);
        if (with_last && $urandom_range(0, 7) == 0) begin
            // stray bytes while halted
            n = $urandom_range(1, 2);
            for (int k = 0; k < n; k++) begin
                junk.data         = 8'($urandom);
                junk.first        = 1'b0;
                junk.last         = 1'($urandom_range(0, 1));
                junk.drain_before = 1'b0;
                byte_stream.insert(byte_stream.size(), junk);
            end
        end
    endtask

    // sender
    always @(posedge aclk) begin : driver
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                parse_byte(on_bus);
                accepted_cnt <= accepted_cnt + 1;
            end
            if (!s_tvalid || s_tready) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    s_tvalid <= 1'b0;
                end else if (byte_stream.size() == 0 ||
                             (byte_stream[0].drain_before && predicted_reports.size() != 0)) begin
                    s_tvalid <= 1'b0;
                end else begin
                    on_bus = byte_stream.pop_front();
                    s_tdata  <= on_bus.data;
                    s_tuser  <= on_bus.first;
                    s_tlast  <= on_bus.last;
                    s_tvalid <= 1'b1;
                    if (hold_left == 0 && accepted_cnt < total_bytes - QUIET_TAIL &&
                        $urandom_range(0, 9) == 0)
                        tx_gap = $urandom_range(1, 15);
                end
            end
        end
    end

    // receiver
    always @(posedge aclk) begin : receiver
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (!hold_done && accepted_cnt >= HOLD_AT) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if (accepted_cnt < total_bytes - QUIET_TAIL && $urandom_range(0, 7) == 0)
                rx_gap = $urandom_range(1, 15);
        end
    end

    always @(posedge aclk) begin : monitor
        report_rec_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (predicted_reports.size() == 0) begin
                log_mismatch("record with none predicted, report_id", 32'(m_tdata[7:0]), '0);
            end else begin
                want = predicted_reports.pop_front();
                if (m_tdata[7:0] !== want.id)
                    log_mismatch("report_id", 32'(m_tdata[7:0]), 32'(want.id));
                if (m_tuser[1:0] !== want.rtype)
                    log_mismatch("report_type", 32'(m_tuser[1:0]), 32'(want.rtype));
                if (m_tdata[39:8] !== want.bits)
                    log_mismatch("report_bits", m_tdata[39:8], want.bits);
                if (m_tdata[55:40] !== want.page)
                    log_mismatch("usage_page", 32'(m_tdata[55:40]), 32'(want.page));
                if (m_tdata[71:56] !== want.code)
                    log_mismatch("usage_code", 32'(m_tdata[71:56]), 32'(want.code));
                if (m_tuser[3:2] !== want.kind)
                    log_mismatch("usage_kind", 32'(m_tuser[3:2]), 32'(want.kind));
            end
        end
    end

    always @(posedge aclk) begin : watchdog
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d of %0d bytes taken, %0d records outstanding",
                     cycles, accepted_cnt, total_bytes, predicted_reports.size());
            $display("tb_hid_report_descriptor_parser_unit NOT OK");
            $finish;
        end
    end

    initial begin
        clear_parser();

        // full-width values, max size times count, repeated usage, usage minimum,
        // all three report types, pop on an empty stack, halt then an ignored byte
        emit_short(hrdp_pkg::TYPE_GLOBAL, hrdp_pkg::TAG_USAGE_PAGE, hrdp_pkg::SIZE_FOUR,
                   32'hFFFF_FFFF);
        emit_short(hrdp_pkg::TYPE_GLOBAL, hrdp_pkg::TAG_REPORT_SIZE, SIZE_TWO, 32'h0000_FFFF);
        emit_short(hrdp_pkg::TYPE_GLOBAL, hrdp_pkg::TAG_REPORT_COUNT, SIZE_TWO, 32'h0000_FFFF);
        emit_short(hrdp_pkg::TYPE_GLOBAL, hrdp_pkg::TAG_REPORT_ID, SIZE_ONE, 32'h0000_00AB);
        emit_short(hrdp_pkg::TYPE_LOCAL, hrdp_pkg::TAG_USAGE, SIZE_ONE, 32'h0000_0011);
        emit_short(hrdp_pkg::TYPE_LOCAL, hrdp_pkg::TAG_USAGE, SIZE_ONE, 32'h0000_0022);
        emit_short(hrdp_pkg::TYPE_MAIN, hrdp_pkg::TAG_INPUT, SIZE_NONE, '0);
        emit_short(hrdp_pkg::TYPE_LOCAL, hrdp_pkg::TAG_USAGE_MIN, SIZE_ONE, 32'h0000_0005);
        emit_short(hrdp_pkg::TYPE_MAIN, hrdp_pkg::TAG_OUTPUT, SIZE_ONE, 32'h0000_0002);
        emit_short(hrdp_pkg::TYPE_MAIN, hrdp_pkg::TAG_FEATURE, SIZE_NONE, '0);
        emit_short(hrdp_pkg::TYPE_MAIN, hrdp_pkg::TAG_END_COLL, SIZE_NONE, '0);
        emit_short(hrdp_pkg::TYPE_MAIN, hrdp_pkg::TAG_COLLECTION, SIZE_NONE, '0);
        emit_short(hrdp_pkg::TYPE_MAIN, hrdp_pkg::TAG_FEATURE, SIZE_ONE, '0);
        queue_byte(hrdp_pkg::END_PREFIX);
        queue_byte({hrdp_pkg::TAG_INPUT, hrdp_pkg::TYPE_MAIN, SIZE_NONE});
        flush_descriptor(1'b1);
        // long item cut short by the last byte
        queue_byte(hrdp_pkg::LONG_PREFIX);
        queue_byte(8'h05);
        flush_descriptor(1'b1);
        // one-byte descriptor: input prefix whose data byte never comes
        queue_byte({hrdp_pkg::TAG_INPUT, hrdp_pkg::TYPE_MAIN, SIZE_ONE});
        flush_descriptor(1'b1);

        while (stream_bytes < TARGET_BYTES) gen_descriptor();
        total_bytes = byte_stream.size();

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        while (accepted_cnt != total_bytes || predicted_reports.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("covered %0d descriptor bytes, %0d report records, nesting up to %0d with %0d %s",
                 total_bytes, n_reports, deepest, full_drops, "collections dropped on a full stack");
        $display("%0d long items skipped, %0d early halts, %0d mismatches",
                 long_items, halts, mismatches);
        if (mismatches == 0) begin
            $display("tb_hid_report_descriptor_parser_unit OK");
        end else begin
            $display("tb_hid_report_descriptor_parser_unit NOT OK");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+sv
sv/hrdp_pkg.sv
sv/hid_report_descriptor_parser_unit.sv
test/tb_hid_report_descriptor_parser_unit.sv
